>>> rtl/bse_pkg.sv
package bse_pkg;

    // Width of one element
    localparam int unsigned DATA_W = 32;

    // Depth of the command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // What the back end does with a queued word
    typedef enum logic {
        CMD_STORE = 1'b0,
        CMD_DROP  = 1'b1
    } cmd_kind_t;

    // One classified input word
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        cmd_kind_t                kind;
    } cmd_t;

endpackage

>>> rtl/bse_ram.sv
module bse_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port, registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/bse_front.sv
module bse_front #(
    parameter int unsigned MAX_N = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [bse_pkg::DATA_W-1:0]    s_value,
    input  logic                                 s_last,
    output logic                                 cmd_valid,
    input  logic                                 cmd_ready,
    output bse_pkg::cmd_t                        cmd
);

    localparam int unsigned CNT_W = $clog2(MAX_N + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             full;
    logic             accept;

    // a set that already holds MAX_N words drops the rest
    assign full      = (count_reg == CNT_W'(MAX_N));
    assign accept    = s_valid && cmd_ready;
    assign s_ready   = cmd_ready;
    assign cmd_valid = s_valid;

    always_comb begin
        cmd.value = s_value;
        cmd.last  = s_last;
        cmd.kind  = full ? bse_pkg::CMD_DROP : bse_pkg::CMD_STORE;
    end

    // words seen in the current set, saturating at capacity
    always_comb begin
        count_next = count_reg;
        if (accept) begin
            if (s_last) begin
                count_next = '0;
            end else if (!full) begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/bse_queue.sv
module bse_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  bse_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output bse_pkg::cmd_t out_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    bse_pkg::cmd_t    slot [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (fill_reg != CNT_W'(DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_cmd   = slot[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            slot[wr_ptr_reg] <= in_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/bse_back.sv
module bse_back #(
    parameter int unsigned MAX_N = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cmd_valid,
    output logic                                 cmd_ready,
    input  bse_pkg::cmd_t                        cmd,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [bse_pkg::DATA_W-1:0]    m_sorted_value,
    output logic                                 m_last_out,
    output logic                                 m_overflowed
);

    localparam int unsigned CNT_W  = $clog2(MAX_N + 1);
    localparam int unsigned ADDR_W = $clog2(MAX_N);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS_START,
        ST_PASS_HEAD,
        ST_PASS_BODY,
        ST_PASS_TAIL,
        ST_EMIT_RD,
        ST_EMIT_LOAD
    } state_t;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic                            ovf_reg, ovf_next;
    logic [CNT_W-1:0]                ptr_reg, ptr_next;
    logic signed [bse_pkg::DATA_W-1:0] carry_reg, carry_next;
    logic                            swapped_reg, swapped_next;

    logic                            m_valid_reg;
    logic signed [bse_pkg::DATA_W-1:0] m_value_reg;
    logic                            m_last_reg;
    logic                            m_ovf_reg;

    logic                            ram_we;
    logic [ADDR_W-1:0]               ram_waddr;
    logic [bse_pkg::DATA_W-1:0]      ram_wdata;
    logic                            ram_re;
    logic [ADDR_W-1:0]               ram_raddr;
    logic [bse_pkg::DATA_W-1:0]      ram_rdata;
    logic signed [bse_pkg::DATA_W-1:0] rd_value;

    logic [CNT_W-1:0]                cnt_after;
    logic [CNT_W-1:0]                ptr_inc;
    logic [CNT_W-1:0]                back_idx;
    logic [CNT_W-1:0]                last_idx;
    logic                            out_free;
    logic                            out_load;
    logic                            out_last;

    bse_ram #(
        .WIDTH (bse_pkg::DATA_W),
        .DEPTH (MAX_N)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_value  = $signed(ram_rdata);
    assign ptr_inc   = ptr_reg + CNT_W'(1);
    assign back_idx  = ptr_reg - CNT_W'(2);
    assign last_idx  = cnt_reg - CNT_W'(1);
    assign out_free  = !m_valid_reg || m_ready;
    assign cmd_ready = (state_reg == ST_IDLE);

    assign m_valid        = m_valid_reg;
    assign m_sorted_value = m_value_reg;
    assign m_last_out     = m_last_reg;
    assign m_overflowed   = m_ovf_reg;

    // sequencer: store words, bubble passes with a carried maximum, emit
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        ptr_next     = ptr_reg;
        carry_next   = carry_reg;
        swapped_next = swapped_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        out_load     = 1'b0;
        out_last     = 1'b0;
        cnt_after    = cnt_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.kind == bse_pkg::CMD_STORE) begin
                        ram_we    = 1'b1;
                        ram_waddr = cnt_reg[ADDR_W-1:0];
                        ram_wdata = cmd.value;
                        cnt_after = cnt_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    cnt_next = cnt_after;
                    if (cmd.last) begin
                        ptr_next   = '0;
                        state_next = (cnt_after >= CNT_W'(2)) ? ST_PASS_START : ST_EMIT_RD;
                    end
                end
            end
            ST_PASS_START: begin
                ram_re       = 1'b1;
                ram_raddr    = '0;
                ptr_next     = CNT_W'(1);
                swapped_next = 1'b0;
                state_next   = ST_PASS_HEAD;
            end
            ST_PASS_HEAD: begin
                carry_next = rd_value;
                ram_re     = 1'b1;
                ram_raddr  = ptr_reg[ADDR_W-1:0];
                ptr_next   = ptr_inc;
                state_next = ST_PASS_BODY;
            end
            ST_PASS_BODY: begin
                // smaller of carry and new word settles one slot back
                ram_we    = 1'b1;
                ram_waddr = back_idx[ADDR_W-1:0];
                if (carry_reg > rd_value) begin
                    ram_wdata    = rd_value;
                    swapped_next = 1'b1;
                end else begin
                    ram_wdata  = carry_reg;
                    carry_next = rd_value;
                end
                if (ptr_reg == cnt_reg) begin
                    state_next = ST_PASS_TAIL;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg[ADDR_W-1:0];
                    ptr_next  = ptr_inc;
                end
            end
            ST_PASS_TAIL: begin
                ram_we    = 1'b1;
                ram_waddr = last_idx[ADDR_W-1:0];
                ram_wdata = carry_reg;
                if (swapped_reg) begin
                    state_next = ST_PASS_START;
                end else begin
                    ptr_next   = '0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = ptr_reg[ADDR_W-1:0];
                state_next = ST_EMIT_LOAD;
            end
            ST_EMIT_LOAD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_last = (ptr_inc == cnt_reg);
                    if (out_last) begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        ptr_next   = ptr_inc;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            ptr_reg     <= '0;
            swapped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            ptr_reg     <= ptr_next;
            swapped_reg <= swapped_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        carry_reg <= carry_next;
        if (out_load) begin
            m_value_reg <= rd_value;
            m_last_reg  <= out_last;
            m_ovf_reg   <= ovf_reg;
        end
    end

    // stored count never passes capacity
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_N))
        else $error("element count above capacity");

    // a pass never reads the slot it writes in the same cycle
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re && (ram_waddr == ram_raddr)))
        else $error("store read and write collide");

    // loading the final word ends the set and clears the bookkeeping
    a_set_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_last) |=> (state_reg == ST_IDLE && cnt_reg == '0 && !ovf_reg))
        else $error("set not closed after final word");

    // output word is not overwritten while waiting
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !out_load)
        else $error("output register overrun");

endmodule

>>> rtl/bubble_sort_engine.sv
// Bubble sort engine: takes a set of signed 32-bit words on s_ (s_last marks
// the final word), keeps up to MAX_N of them, sorts them ascending and returns
// them on m_ with m_last_out on the final word. Words beyond MAX_N are dropped
// and every result of that set carries m_overflowed. Input words pass through a
// four-entry queue at one per cycle while the queue has room, so the first
// words of a new set can be queued while the previous one is still sorting or
// draining. The back end stores one word per cycle while it is idle. Sorting
// runs on a store with one read and one write port and one compare per cycle;
// up to n passes over n words are needed (one more pass than the number of
// swapping passes). Emitting waits while m_ready is low.
// There is no start-up clearing pass.
module bubble_sort_engine #(
    parameter int unsigned MAX_N = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [bse_pkg::DATA_W-1:0]    s_value,
    input  logic                                 s_last,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [bse_pkg::DATA_W-1:0]    m_sorted_value,
    output logic                                 m_last_out,
    output logic                                 m_overflowed
);

    bse_pkg::cmd_t front_cmd;
    logic          front_valid;
    logic          front_ready;
    bse_pkg::cmd_t back_cmd;
    logic          back_valid;
    logic          back_ready;

    bse_front #(
        .MAX_N (MAX_N)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_value   (s_value),
        .s_last    (s_last),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    bse_queue #(
        .DEPTH (bse_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_cmd   (back_cmd)
    );

    bse_back #(
        .MAX_N (MAX_N)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (back_valid),
        .cmd_ready      (back_ready),
        .cmd            (back_cmd),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_last_out     (m_last_out),
        .m_overflowed   (m_overflowed)
    );

endmodule

>>> test/bubble_sort_engine_tb.sv
`timescale 1ns / 1ps

module bubble_sort_engine_tb;

    localparam int unsigned DATA_W       = bse_pkg::DATA_W;
    localparam int unsigned CAPACITY     = 32;
    localparam int unsigned HOLD_CYCLES  = 800;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned RANDOM_WORDS = 180;
    localparam int unsigned CALM_WORDS   = 60;
    localparam int unsigned IDLE_PCT     = 29;
    localparam int unsigned DRAIN_CYCLES = 100;

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    // One word of a sorted run as it should leave the block
    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     overflow;
    } sorted_word_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_value = '0;
    logic                     s_last = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_sorted_value;
    logic                     m_last_out;
    logic                     m_overflowed;

    // Stimulus control
    logic        no_idle = 1'b0;
    logic        hold_start = 1'b0;
    int unsigned hold_left = 0;
    logic        valid_held = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned words_sent = 0;

    // Predictor state: the set being collected and the runs still owed
    logic signed [DATA_W-1:0] open_set[$];
    logic                     open_set_dropped = 1'b0;
    sorted_word_t             expected_words[$];

    bubble_sort_engine #(
        .MAX_N(CAPACITY)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_value(m_sorted_value),
        .m_last_out    (m_last_out),
        .m_overflowed  (m_overflowed)
    );

    always #10 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: random stalls unless held off or in a calm stretch
    always @(posedge aclk) begin
        if (hold_start || hold_left > 1) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Take one accepted word into the open set; on the final word sort the set
    // ascending and queue the run it must produce
    function automatic void absorb_word(input logic signed [DATA_W-1:0] value,
                                        input logic last);
        logic signed [DATA_W-1:0] ordered[$];
        logic signed [DATA_W-1:0] held;
        sorted_word_t             w;
        int                       j;
        words_sent++;
        if (open_set.size() < CAPACITY) begin
            open_set.push_back(value);
        end else begin
            open_set_dropped = 1'b1;
        end
        if (last) begin
            ordered = open_set;
            for (int i = 1; i < ordered.size(); i++) begin
                held = ordered[i];
                j = i - 1;
                while (j >= 0 && ordered[j] > held) begin
                    ordered[j + 1] = ordered[j];
                    j--;
                end
                ordered[j + 1] = held;
            end
            for (int k = 0; k < ordered.size(); k++) begin
                w.value    = ordered[k];
                w.last     = (k == ordered.size() - 1);
                w.overflow = open_set_dropped;
                expected_words.push_back(w);
            end
            open_set.delete();
            open_set_dropped = 1'b0;
        end
    endfunction

    // Compare each accepted result word with the oldest one owed
    always @(posedge aclk) begin : check_words
        sorted_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %0d", m_sorted_value));
            end else begin
                want = expected_words.pop_front();
                if (m_sorted_value !== want.value) begin
                    report_mismatch($sformatf("value %0d, expected %0d",
                                              m_sorted_value, want.value));
                end
                if (m_last_out !== want.last) begin
                    report_mismatch($sformatf("last_out %b, expected %b",
                                              m_last_out, want.last));
                end
                if (m_overflowed !== want.overflow) begin
                    report_mismatch($sformatf("overflowed %b, expected %b",
                                              m_overflowed, want.overflow));
                end
            end
        end
    end

    // Offer one word, wait for it to be taken, maybe idle afterwards.
    // Valid stays up between back-to-back words.
    task automatic send_word(input logic signed [DATA_W-1:0] value, input logic last);
        s_valid    <= 1'b1;
        s_value    <= value;
        s_last     <= last;
        valid_held = 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        absorb_word(value, last);
        if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid    <= 1'b0;
            valid_held = 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < IDLE_PCT) @(posedge aclk);
        end
    endtask

    // Drop valid before any wait that is not a send
    task automatic stop_sending();
        if (valid_held) begin
            s_valid    <= 1'b0;
            valid_held = 1'b0;
        end
    endtask

    // Mix of extremes, small values (for duplicates) and full-range values
    function automatic logic signed [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return $signed($urandom_range(0, 2)) - 1;
            3, 4:    return $signed($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_set(input int unsigned len);
        for (int unsigned i = 1; i <= len; i++) begin
            send_word(rand_word(), i == len);
        end
    endtask

    // Single words at both extremes, duplicates, mixed signs, presorted and
    // reversed sets, alternating bit patterns
    task automatic test_directed();
        send_word(VAL_MIN, 1'b1);
        send_word(VAL_MAX, 1'b1);
        send_word(32'sd5, 1'b0);
        send_word(32'sd5, 1'b1);
        send_word(VAL_MAX, 1'b0);
        send_word(VAL_MIN, 1'b0);
        send_word(32'sd0, 1'b0);
        send_word(-32'sd1, 1'b0);
        send_word(32'sd1, 1'b1);
        send_word(32'sd4, 1'b0);
        send_word(32'sd3, 1'b0);
        send_word(32'sd2, 1'b0);
        send_word(32'sd1, 1'b1);
        send_word(-32'sd3, 1'b0);
        send_word(-32'sd2, 1'b0);
        send_word(-32'sd1, 1'b1);
        send_word(32'sh5555_5555, 1'b0);
        send_word(32'shAAAA_AAAA, 1'b0);
        send_word(32'sh7FFF_FFFE, 1'b0);
        send_word(32'sh8000_0001, 1'b1);
    endtask

    // Full store, final word dropped, and a set well past capacity
    task automatic test_capacity();
        send_set(CAPACITY);
        send_set(CAPACITY + 1);
        send_set(CAPACITY + 13);
        send_set(2);
    endtask

    // Receiver holds off while several sets keep coming, so the input stalls
    task automatic test_backpressure();
        stop_sending();
        hold_start <= 1'b1;
        @(posedge aclk);
        hold_start <= 1'b0;
        send_set(12);
        send_set(CAPACITY);
        send_set(9);
        send_set(5);
    endtask

    // Random sets, mostly short; a calm stretch at the start
    task automatic test_random();
        int unsigned start_count;
        start_count = words_sent;
        no_idle <= 1'b1;
        while (words_sent - start_count < RANDOM_WORDS) begin
            if (no_idle && words_sent - start_count >= CALM_WORDS) begin
                no_idle <= 1'b0;
            end
            if ($urandom_range(0, 19) == 0) begin
                send_set($urandom_range(CAPACITY - 2, CAPACITY + 8));
            end else begin
                send_set($urandom_range(1, 10));
            end
        end
        no_idle <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_capacity();
        test_backpressure();
        test_random();
        stop_sending();

        // Drain, then watch a while for stray words
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
